// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros; compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Assertion that is disabled while the reset is high.
`define RRSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion that also holds during reset.
`define RRSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRSS_ASSERT(label, clk, rst, prop, msg)
`define RRSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/rrss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_pkg
// Field widths, codes and the result beat type of the slice scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

   localparam int ID_W     = 8;
   localparam int IN_TIME_W = 16;
   localparam int SLICE_W  = 16;
   localparam int LEFT_W   = 5;
   localparam int STATUS_W = 2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_RAN      = 2'd0,
      STATUS_LOADED   = 2'd1,
      STATUS_REJECTED = 2'd2,
      STATUS_IDLE     = 2'd3
   } status_type;

   typedef struct packed {
      status_type            status;
      logic [ID_W-1:0]       ran_id;
      logic [IN_TIME_W-1:0]  executed_time;
      logic                  finished;
      logic [LEFT_W-1:0]     jobs_left;
   } rsp_type;

endpackage

// File: rtl/rrss_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_req_if
// Request channel: load or step beats with valid/ready.
// ----------------------------------------------------------------------------
interface rrss_req_if;
   import rrss_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [ID_W-1:0]      process_id;
   logic [IN_TIME_W-1:0] total_time;

   modport source (output valid, kind, process_id, total_time, input ready);
   modport sink   (input valid, kind, process_id, total_time, output ready);
endinterface

// File: rtl/rrss_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_rsp_if
// Response channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface rrss_rsp_if;
   import rrss_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ID_W-1:0]      ran_id;
   logic [IN_TIME_W-1:0] executed_time;
   logic                 finished;
   logic [LEFT_W-1:0]    jobs_left;

   modport source (output valid, status, ran_id, executed_time, finished, jobs_left,
                   input ready);
   modport sink   (input valid, status, ran_id, executed_time, finished, jobs_left,
                   output ready);
endinterface

// File: rtl/rrss_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_csr_if
// Register write channel for the time slice.
// ----------------------------------------------------------------------------
interface rrss_csr_if;
   import rrss_pkg::*;

   logic               valid;
   logic               ready;
   logic [SLICE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/round_robin_slice_scheduler_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_core
// Round-robin time-slice scheduler over a table of job slots.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  carries load beats (kind 0: process_id, total_time) and step
//            beats (kind 1). Loads fill the table in ring order; once it is
//            full or after the first step they are rejected until it empties.
//   rsp_bus  returns exactly one result beat per request beat, in order.
//   csr_bus  writes the time slice; always ready, write it only while idle.
// Timing:
//   Each beat is decided in the cycle it is accepted and its result sits in
//   the output register in the following cycle: one beat per cycle while
//   rsp_bus.ready stays high. The decision path is one add and compare on
//   the current slot plus the ring priority picker over the active mask.
// Stall:
//   While a result waits and rsp_bus.ready is low, req_bus.ready drops; no
//   beat is lost. Once the receiver takes it, a new beat enters that cycle.
// Reset:
//   Synchronous, active high. Clears the active mask, counters and pointer
//   and sets the slice to 1; slot contents are don't-care until loaded.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_core #(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   rrss_req_if.sink   req_bus,
   rrss_rsp_if.source rsp_bus,
   rrss_csr_if.sink   csr_bus
);
   import rrss_pkg::*;

   localparam int SLOT_W = $clog2(MAX_JOBS);
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);
   localparam int SUM_W  = ((TIME_BITS > SLICE_W) ? TIME_BITS : SLICE_W) + 1;

   // Slot table: contents have no reset, only the active mask does.
   logic [ID_W-1:0]      id_ff    [MAX_JOBS];
   logic [TIME_BITS-1:0] total_ff [MAX_JOBS];
   logic [TIME_BITS-1:0] exec_ff  [MAX_JOBS];

   logic [MAX_JOBS-1:0]  active_ff,  active_in;
   logic [CNT_W-1:0]     fill_ff,    fill_in;
   logic [CNT_W-1:0]     count_ff,   count_in;
   logic [SLOT_W-1:0]    cur_ff,     cur_in;
   logic                 started_ff, started_in;
   logic [SLICE_W-1:0]   slice_ff;

   logic                 accept;
   logic                 stage_ready;
   logic                 load_we;
   logic                 exec_we;
   logic [SLOT_W-1:0]    fill_slot;
   logic [ID_W-1:0]      cur_id;
   logic [TIME_BITS-1:0] cur_total;
   logic [TIME_BITS-1:0] cur_exec;
   logic [SUM_W-1:0]     sum;
   logic                 retire;
   logic [TIME_BITS-1:0] new_exec;
   logic [MAX_JOBS-1:0]  mask_after;
   logic                 nxt_found;
   logic [SLOT_W-1:0]    nxt_slot;
   rsp_type              beat;

   assign req_bus.ready = stage_ready;
   assign accept        = req_bus.valid && stage_ready;
   assign csr_bus.ready = 1'b1;
   assign fill_slot     = fill_ff[SLOT_W-1:0];

   // The pointer always rests on an active slot whenever any slot is active,
   // so the current job is read straight from the pointer.
   assign cur_id    = id_ff[cur_ff];
   assign cur_total = total_ff[cur_ff];
   assign cur_exec  = exec_ff[cur_ff];

   // Sum at full width so a large slice never wraps past the total.
   assign sum      = SUM_W'(cur_exec) + SUM_W'(slice_ff);
   assign retire   = (sum >= SUM_W'(cur_total)) || (count_ff == CNT_W'(1));
   assign new_exec = retire ? cur_total : TIME_BITS'(sum);

   always_comb begin
      mask_after = active_ff;
      if (retire) begin
         mask_after[cur_ff] = 1'b0;
      end
   end

   rrss_next_slot #(
      .MAX_JOBS (MAX_JOBS)
   ) u_next_slot (
      .mask      (mask_after),
      .from_slot (cur_ff),
      .found     (nxt_found),
      .slot      (nxt_slot)
   );

   // Decide the beat: next state and the result beat in one pass.
   always_comb begin
      active_in  = active_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      started_in = started_ff;
      load_we    = 1'b0;
      exec_we    = 1'b0;
      beat       = '0;
      beat.status = STATUS_IDLE;

      if (accept && (req_bus.kind == KIND_LOAD)) begin
         if (started_ff || (fill_ff >= CNT_W'(MAX_JOBS))) begin
            beat.status = STATUS_REJECTED;
         end else begin
            // Append at the next free slot of the ring.
            load_we              = 1'b1;
            active_in[fill_slot] = 1'b1;
            fill_in              = fill_ff + CNT_W'(1);
            count_in             = count_ff + CNT_W'(1);
            beat.status          = STATUS_LOADED;
         end
      end else if (accept) begin
         if (count_ff == '0) begin
            beat.status = STATUS_IDLE;
         end else begin
            exec_we            = 1'b1;
            active_in          = mask_after;
            count_in           = count_ff - CNT_W'(retire);
            started_in         = 1'b1;
            beat.status        = STATUS_RAN;
            beat.ran_id        = cur_id;
            beat.executed_time = IN_TIME_W'(new_exec);
            beat.finished      = retire;
            if (nxt_found) begin
               cur_in = nxt_slot;
            end else begin
               // Last job retired: empty the table and reopen loading.
               fill_in    = '0;
               cur_in     = '0;
               started_in = 1'b0;
            end
         end
      end
      beat.jobs_left = LEFT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         fill_ff    <= '0;
         count_ff   <= '0;
         cur_ff     <= '0;
         started_ff <= 1'b0;
         slice_ff   <= SLICE_W'(1);
      end else begin
         active_ff  <= active_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         cur_ff     <= cur_in;
         started_ff <= started_in;
         if (csr_bus.valid) begin
            slice_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         id_ff[fill_slot]    <= req_bus.process_id;
         total_ff[fill_slot] <= TIME_BITS'(req_bus.total_time);
         exec_ff[fill_slot]  <= '0;
      end
      if (exec_we) begin
         exec_ff[cur_ff] <= new_exec;
      end
   end

   rrss_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_ready (stage_ready),
      .in_beat  (beat),
      .rsp_bus  (rsp_bus)
   );

   // Job counter tracks the active mask.
   `RRSS_ASSERT(a_count_matches_mask, clock, reset, ($countones(active_ff) == int'(count_ff)), "job count out of step with active mask")
   // Pointer rests on an active slot while jobs remain.
   `RRSS_ASSERT(a_cur_on_active, clock, reset, ((count_ff != '0) |-> active_ff[cur_ff]), "pointer on a retired slot")
   // Scheduling only runs while jobs remain.
   `RRSS_ASSERT(a_started_has_jobs, clock, reset, (started_ff |-> (count_ff != '0)), "started with an empty ring")
   // Never more active jobs than loaded slots.
   `RRSS_ASSERT(a_count_le_fill, clock, reset, (count_ff <= fill_ff), "more active jobs than loaded slots")
endmodule

// File: rtl/rrss_next_slot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_next_slot
// Ring priority picker: first set bit strictly after a start slot, wrapping.
// ----------------------------------------------------------------------------
module rrss_next_slot #(
   parameter int MAX_JOBS = 16
) (
   input  logic [MAX_JOBS-1:0]         mask,
   input  logic [$clog2(MAX_JOBS)-1:0] from_slot,
   output logic                        found,
   output logic [$clog2(MAX_JOBS)-1:0] slot
);
   localparam int SLOT_W = $clog2(MAX_JOBS);

   logic [MAX_JOBS-1:0] upper;
   logic [SLOT_W-1:0]   pick_hi;
   logic [SLOT_W-1:0]   pick_lo;

   // Split the ring: bits after the start slot first, then the wrap part.
   always_comb begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         upper[i] = mask[i] && (SLOT_W'(i) > from_slot);
      end
   end

   always_comb begin
      pick_hi = '0;
      pick_lo = '0;
      for (int i = MAX_JOBS - 1; i >= 0; i--) begin
         if (upper[i]) begin
            pick_hi = SLOT_W'(i);
         end
         if (mask[i]) begin
            pick_lo = SLOT_W'(i);
         end
      end
   end

   assign found = |mask;
   assign slot  = (|upper) ? pick_hi : pick_lo;
endmodule

// File: rtl/rrss_rsp_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_rsp_stage
// Result register: holds a beat until the receiver takes it.
// ----------------------------------------------------------------------------
module rrss_rsp_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rrss_pkg::rsp_type   in_beat,
   rrss_rsp_if.source          rsp_bus
);
   import rrss_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type beat_ff;

   // Take a new beat whenever the register is empty or drains this cycle.
   assign in_ready = !valid_ff || rsp_bus.ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= in_beat;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.status        = beat_ff.status;
   assign rsp_bus.ran_id        = beat_ff.ran_id;
   assign rsp_bus.executed_time = beat_ff.executed_time;
   assign rsp_bus.finished      = beat_ff.finished;
   assign rsp_bus.jobs_left     = beat_ff.jobs_left;
endmodule
